>>> hw/rtl/hrf_pkg.sv
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared constants, types and pattern tables for the request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int LENGTH_WIDTH = 32;
   localparam int BODY_LENGTH_WIDTH = 32;
   localparam int NAME_LENGTH = 15;
   localparam int END_LENGTH = 4;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // end of headers: cr lf cr lf, entry 0 first
   localparam logic [END_LENGTH-1:0][7:0] END_PATTERN = {CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR};

   typedef enum logic [1:0] {
      LP_NAME   = 2'd0,
      LP_SKIP   = 2'd1,
      LP_DIGITS = 2'd2,
      LP_DONE   = 2'd3
   } length_phase_type;

   typedef struct packed {
      logic [7:0]                   out_byte;
      logic                         in_body;
      logic                         last;
      logic [BODY_LENGTH_WIDTH-1:0] body_length;
      logic                         length_saturated;
   } rsp_item_type;

   // "Content-Length:" one character per index
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h6E;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6E;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2D;
         4'd8:    c = 8'h4C;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6E;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         4'd14:   c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/http_request_framer_core.sv
// ----------------------------------------------------------------------------
// http_request_framer_core
// Frames http requests from a byte stream using the content-length header.
//
// Usage: bytes enter on the req_ stream, one per handshake. Every byte comes
// back on the rsp_ stream unchanged, tagged as header or body in tuser, with
// the length parsed so far and tlast on the final byte of each request.
// The header end is the first cr lf cr lf; the first "Content-Length:"
// before it sets how many body bytes follow. After the last byte the
// framer starts over on the next byte.
// Throughput: one byte per cycle while req_tready is high; all per-byte work is one pass of
// matching, a shift-add digit step and a body counter decrement.
// Stall: a two-entry output buffer (output register and skid register)
// keeps req_tready high while one result waits; req_tready drops only
// when both entries are full. No item is lost or repeated.
// Reset: all parse state clears, both output entries empty, next byte is
// the first of a new request.
// ----------------------------------------------------------------------------
module http_request_framer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] body_length
   output logic [1:0]  rsp_tuser,   // [0] in_body, [1] length_saturated
   output logic        rsp_tlast    // last
);

   localparam int LW = hrf_pkg::LENGTH_WIDTH;
   localparam logic [LW-1:0] LENGTH_MAX = '1;

   // parse state
   logic [1:0]                   end_match_count_ff, end_match_count_in;
   logic [3:0]                   name_match_count_ff, name_match_count_in;
   hrf_pkg::length_phase_type    length_phase_ff, length_phase_in;
   logic [LW-1:0]                parsed_length_ff, parsed_length_in;
   logic                         overflow_seen_ff, overflow_seen_in;
   logic                         body_phase_ff, body_phase_in;
   logic [LW-1:0]                body_remaining_ff, body_remaining_in;

   // output buffer
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         skid_valid_ff, skid_valid_in;
   hrf_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;
   hrf_pkg::rsp_item_type        skid_item_ff, skid_item_in;

   logic                         req_accept;
   logic                         rsp_accept;
   logic [7:0]                   b;
   logic                         is_blank;
   logic                         is_digit;
   logic [LW+3:0]                digit_ext;
   logic [LW+3:0]                times_ten;
   logic [LW-1:0]                remaining_dec;
   logic [2:0]                   end_next;
   logic                         last_hit;
   hrf_pkg::rsp_item_type        new_item;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign b = req_tdata;

   assign is_blank = (b == hrf_pkg::CHAR_SPACE) || (b inside {[hrf_pkg::CHAR_TAB:hrf_pkg::CHAR_CR]});
   assign is_digit = b inside {[hrf_pkg::CHAR_ZERO:hrf_pkg::CHAR_NINE]};
   assign digit_ext = (LW+4)'(b - hrf_pkg::CHAR_ZERO);
   assign times_ten = ((LW+4)'(parsed_length_ff) << 3) + ((LW+4)'(parsed_length_ff) << 1)
                      + digit_ext;
   assign remaining_dec = (body_remaining_ff != '0) ? body_remaining_ff - LW'(1)
                                                     : body_remaining_ff;

   // next state
   always_comb begin
      end_match_count_in  = end_match_count_ff;
      name_match_count_in = name_match_count_ff;
      length_phase_in     = length_phase_ff;
      parsed_length_in    = parsed_length_ff;
      overflow_seen_in    = overflow_seen_ff;
      body_phase_in       = body_phase_ff;
      body_remaining_in   = body_remaining_ff;
      end_next            = 3'd0;
      last_hit            = 1'b0;
      if (body_phase_ff) begin
         body_remaining_in = remaining_dec;
         last_hit = (remaining_dec == '0);
      end else begin
         case (length_phase_ff)
            hrf_pkg::LP_NAME: begin
               if (b == hrf_pkg::name_char(name_match_count_ff)) begin
                  if (name_match_count_ff == 4'(hrf_pkg::NAME_LENGTH - 1)) begin
                     length_phase_in = hrf_pkg::LP_SKIP;
                     name_match_count_in = 4'd0;
                  end else begin
                     name_match_count_in = name_match_count_ff + 4'd1;
                  end
               end else begin
                  name_match_count_in = (b == hrf_pkg::name_char(4'd0)) ? 4'd1 : 4'd0;
               end
            end
            hrf_pkg::LP_SKIP, hrf_pkg::LP_DIGITS: begin
               if (length_phase_ff == hrf_pkg::LP_SKIP && is_blank) begin
                  length_phase_in = length_phase_ff;
               end else if (is_digit) begin
                  length_phase_in = hrf_pkg::LP_DIGITS;
                  if (times_ten[LW+3:LW] != 4'd0) begin
                     parsed_length_in = LENGTH_MAX;
                     overflow_seen_in = 1'b1;
                  end else begin
                     parsed_length_in = times_ten[LW-1:0];
                  end
               end else begin
                  length_phase_in = hrf_pkg::LP_DONE;
               end
            end
            default: begin
               length_phase_in = length_phase_ff;
            end
         endcase
         if (b == hrf_pkg::END_PATTERN[end_match_count_ff]) begin
            end_next = {1'b0, end_match_count_ff} + 3'd1;
         end else begin
            end_next = (b == hrf_pkg::CHAR_CR) ? 3'd1 : 3'd0;
         end
         if (end_next == 3'(hrf_pkg::END_LENGTH)) begin
            end_match_count_in = 2'd0;
            body_phase_in = 1'b1;
            body_remaining_in = parsed_length_in;
            last_hit = (parsed_length_in == '0);
         end else begin
            end_match_count_in = end_next[1:0];
         end
      end
   end

   // result item
   always_comb begin
      new_item.out_byte         = b;
      new_item.in_body          = body_phase_ff;
      new_item.last             = last_hit;
      new_item.body_length      = hrf_pkg::BODY_LENGTH_WIDTH'(parsed_length_in);
      new_item.length_saturated = overflow_seen_in;
   end

   // output register and skid register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_item_in  = skid_item_ff;
      if (rsp_accept) begin
         if (skid_valid_ff) begin
            rsp_item_in = skid_item_ff;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            rsp_item_in = new_item;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff) begin
            rsp_item_in = new_item;
            rsp_valid_in = 1'b1;
         end else begin
            skid_item_in = new_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_match_count_ff  <= 2'd0;
         name_match_count_ff <= 4'd0;
         length_phase_ff     <= hrf_pkg::LP_NAME;
         parsed_length_ff    <= '0;
         overflow_seen_ff    <= 1'b0;
         body_phase_ff       <= 1'b0;
         body_remaining_ff   <= '0;
         rsp_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_accept) begin
            if (last_hit) begin
               end_match_count_ff  <= 2'd0;
               name_match_count_ff <= 4'd0;
               length_phase_ff     <= hrf_pkg::LP_NAME;
               parsed_length_ff    <= '0;
               overflow_seen_ff    <= 1'b0;
               body_phase_ff       <= 1'b0;
               body_remaining_ff   <= '0;
            end else begin
               end_match_count_ff  <= end_match_count_in;
               name_match_count_ff <= name_match_count_in;
               length_phase_ff     <= length_phase_in;
               parsed_length_ff    <= parsed_length_in;
               overflow_seen_ff    <= overflow_seen_in;
               body_phase_ff       <= body_phase_in;
               body_remaining_ff   <= body_remaining_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.body_length, rsp_item_ff.out_byte};
   assign rsp_tuser  = {rsp_item_ff.length_saturated, rsp_item_ff.in_body};
   assign rsp_tlast  = rsp_item_ff.last;

   // skid entry is only used behind a full output register
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while output register empty");

   // a request in its body always has bytes left to count
   assert property (@(posedge clock) disable iff (reset)
      body_phase_ff |-> (parsed_length_ff != '0) && (body_remaining_ff != '0))
      else $error("body phase with zero length or nothing remaining");

   // saturation pins the length at its maximum
   assert property (@(posedge clock) disable iff (reset)
      overflow_seen_ff |-> (parsed_length_ff == LENGTH_MAX))
      else $error("overflow flag set without clamped length");

   // name matching never holds a completed match
   assert property (@(posedge clock) disable iff (reset)
      name_match_count_ff != 4'(hrf_pkg::NAME_LENGTH))
      else $error("name match counter reached pattern length");

endmodule
